// ----- rtl/multi_waveform_generator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-waveform generator
// Shared property shapes used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define MULTI_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mwg same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mwg next-cycle check failed");

`endif

// ----- rtl/mwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwg_pkg
// Types, constants and helpers shared by the waveform generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwg_pkg;

  localparam int unsigned PHASE_BITS_DEF  = 16;
  localparam int unsigned COLUMN_BITS_DEF = 12;

  // Turn-scaling constant, round(2^40 * 0.01 / (2*pi)).
  localparam logic [30:0] TURN_K = 31'd1749927106;

  // Odd sine polynomial coefficients in Q30.
  localparam logic [30:0] C_A1 = 31'd1686629713;
  localparam logic [30:0] C_A3 = 31'd693598670;
  localparam logic [30:0] C_A5 = 31'd85569306;
  localparam logic [30:0] C_A7 = 31'd5026995;
  localparam logic [30:0] C_A9 = 31'd172273;

  localparam int unsigned POLY_CELLS = 4;
  localparam int unsigned QUO_BITS   = 20;
  localparam int unsigned REM_W      = 44;
  localparam int unsigned DEN_W      = 32;

  localparam logic signed [19:0] VAL_MAX = 20'sd524287;
  localparam logic signed [19:0] VAL_MIN = -20'sd524288;
  localparam logic signed [19:0] VAL_ONE = 20'sd4096;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_COSINE   = 3'd1,
    WAVE_TANGENT  = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_SAWTOOTH = 3'd4
  } wave_e;

  typedef enum logic [1:0] {
    REG_WAVE_TYPE = 2'd0,
    REG_FREQUENCY = 2'd1,
    REG_AMPLITUDE = 2'd2,
    REG_MID_Y     = 2'd3
  } cfg_reg_e;

  // One lane of the sine evaluator: quarter position, its square, the
  // running Horner term and the half-turn sign.
  typedef struct packed {
    logic [30:0] r;
    logic [30:0] x2;
    logic [30:0] t;
    logic        neg;
  } lane_t;

  // Partial state of the restoring divider.
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DEN_W-1:0]    den;
    logic [QUO_BITS-1:0] quo;
  } div_t;

  // Side data that rides along with the divider.
  typedef struct packed {
    logic signed [19:0] alt;
    logic               tneg;
    logic               zero;
    logic               spos;
    logic               ovf;
  } pass_t;

  // Coefficient used by poly cell k, highest order first after A9.
  function automatic logic [30:0] poly_coef(int unsigned k);
    logic [30:0] c;
    unique case (k)
      0:       c = C_A7;
      1:       c = C_A5;
      2:       c = C_A3;
      default: c = C_A1;
    endcase
    return c;
  endfunction

  // Fold a 32-bit turn phase into a quarter-turn position and a sign.
  function automatic lane_t lane_setup(logic [31:0] ph);
    lane_t l;
    l.r   = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
    l.x2  = '0;
    l.t   = C_A9;
    l.neg = ph[31];
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mwg_poly_cell.sv -----
// ----------------------------------------------------------------------------
// mwg_poly_cell
// One Horner step of the sine polynomial: t <= COEF - x2 * t / 2^30.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_poly_cell #(
  parameter logic [30:0] COEF = mwg_pkg::C_A1
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire mwg_pkg::lane_t lane_i,
  output mwg_pkg::lane_t     lane_o
);

  logic [61:0]    prod;
  logic [31:0]    step;
  mwg_pkg::lane_t lane_d, lane_q;

  assign prod = 62'(lane_i.x2) * 62'(lane_i.t);
  assign step = {1'b0, COEF} - prod[61:30];

  always_comb begin
    lane_d   = lane_i;
    lane_d.t = step[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

// ----- rtl/mwg_div_cell.sv -----
// ----------------------------------------------------------------------------
// mwg_div_cell
// One restoring division step that resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire mwg_pkg::div_t  div_i,
  input  wire mwg_pkg::pass_t pass_i,
  output mwg_pkg::div_t       div_o,
  output mwg_pkg::pass_t      pass_o
);

  localparam int unsigned CW = mwg_pkg::DEN_W + mwg_pkg::QUO_BITS;

  logic [CW-1:0]  sub, remx, diff;
  logic           take;
  mwg_pkg::div_t  div_d, div_q;
  mwg_pkg::pass_t pass_q;

  assign sub  = CW'(div_i.den) << SHIFT;
  assign remx = CW'(div_i.rem);
  assign take = (remx >= sub);
  assign diff = remx - sub;

  always_comb begin
    div_d = div_i;
    if (take) begin
      div_d.rem = diff[mwg_pkg::REM_W-1:0];
      div_d.quo = div_i.quo | (mwg_pkg::QUO_BITS'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      pass_q <= pass_i;
    end
  end

  assign div_o  = div_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

// ----- rtl/multi_waveform_generator_unit.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_generator_unit
// Pipelined function generator producing one plotted waveform column per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Each input transaction carries a pixel column and a scroll time. The unit
// forms the phase (x + time) * frequency * 0.01 rad, reduces it to a fraction
// of a turn and returns the selected waveform value (signed Q8.12) together
// with the plotted screen row mid_y - value * amplitude. The datapath is a
// fixed 32-stage pipeline: three phase stages, a sine/cosine evaluator built
// from a row of Horner cells, and a row of twenty restoring divider cells for
// the tangent. One transaction is accepted every clock unless a held result
// stalls the output; the whole row advances together, so a stalled output
// holds the pipeline. Configuration is written through cfg_we_i and is
// only to be changed while no transaction is in flight.
`default_nettype none

`include "multi_waveform_generator_unit_defines.svh"

module multi_waveform_generator_unit #(
  parameter int unsigned PHASE_BITS  = mwg_pkg::PHASE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = mwg_pkg::COLUMN_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Fields from bit 0: pixel_x[11:0], time_offset[35:12], zero pad.
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: wave_value[19:0], screen_row[35:20], zero pad.
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [11:0] cfg_data_i
);

  localparam int unsigned NSTAGE = 32;
  localparam int unsigned NPOLY  = mwg_pkg::POLY_CELLS;
  localparam int unsigned NDIV   = mwg_pkg::QUO_BITS;
  localparam int unsigned SAWD   = NPOLY + 2;
  localparam logic [15:0] COL_MASK = 16'((32'd1 << COLUMN_BITS) - 32'd1);

  // Configuration registers.
  logic [2:0]  wave_type_q;
  logic [11:0] freq_q;
  logic [7:0]  amp_q;
  logic [10:0] mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_type_q <= 3'd0;
      freq_q      <= 12'd768;
      amp_q       <= 8'd100;
      mid_q       <= 11'd300;
    end else if (cfg_we_i) begin
      unique case (mwg_pkg::cfg_reg_e'(cfg_addr_i))
        mwg_pkg::REG_WAVE_TYPE: wave_type_q <= cfg_data_i[2:0];
        mwg_pkg::REG_FREQUENCY: freq_q      <= cfg_data_i;
        mwg_pkg::REG_AMPLITUDE: amp_q       <= cfg_data_i[7:0];
        mwg_pkg::REG_MID_Y:     mid_q       <= cfg_data_i[10:0];
        default:                ;
      endcase
    end
  end

  // The whole row advances together whenever the output slot can move.
  logic              en;
  logic [NSTAGE-1:0] vld_q;

  assign en            = !vld_q[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: column plus time, scaled by the frequency.
  logic [15:0] col;
  logic [24:0] s_sum;
  logic [36:0] p_q;

  assign col   = {4'b0, s_axis_tdata[11:0]} & COL_MASK;
  assign s_sum = {1'b0, col, 8'b0} + {1'b0, s_axis_tdata[35:12]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= 37'(s_sum) * 37'(freq_q);
    end
  end

  // Stage 2: the turn scaling is split into two partial products.
  logic [47:0] pkh_q;
  logic [50:0] pkl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pkh_q <= 48'(p_q[36:20]) * 48'(mwg_pkg::TURN_K);
      pkl_q <= 51'(p_q[19:0]) * 51'(mwg_pkg::TURN_K);
    end
  end

  // Stage 3: combine, keep the top PHASE_BITS fraction bits, left-align.
  logic [55:0] sum56;
  logic [31:0] ph_q;

  assign sum56 = {pkh_q[35:0], 20'b0} + {5'b0, pkl_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q <= {sum56[55 -: PHASE_BITS], {(32 - PHASE_BITS){1'b0}}};
    end
  end

  // Stage 4: fold into quarters for sine (lane 0) and cosine (lane 1).
  mwg_pkg::lane_t setup_l [2];
  mwg_pkg::lane_t poly_l  [2][NPOLY+1];
  logic [61:0]    sq_prod [2];
  logic signed [19:0] saw_q [SAWD];

  assign setup_l[0] = mwg_pkg::lane_setup(ph_q);
  assign setup_l[1] = mwg_pkg::lane_setup(ph_q + 32'h4000_0000);

  for (genvar l = 0; l < 2; l++) begin : g_lane
    mwg_pkg::lane_t st4_d, st4_q;

    assign sq_prod[l] = 62'(setup_l[l].r) * 62'(setup_l[l].r);

    always_comb begin
      st4_d    = setup_l[l];
      st4_d.x2 = sq_prod[l][60:30];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st4_q <= st4_d;
      end
    end

    assign poly_l[l][0] = st4_q;

    for (genvar k = 0; k < NPOLY; k++) begin : g_poly
      mwg_poly_cell #(
        .COEF (mwg_pkg::poly_coef(k))
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .lane_i (poly_l[l][k]),
        .lane_o (poly_l[l][k+1])
      );
    end
  end

  // Sawtooth is known from the phase alone and waits in a short delay line.
  always_ff @(posedge clk_i) begin
    if (en) begin
      saw_q[0] <= 20'({~ph_q[31], ph_q[30:19]}) - mwg_pkg::VAL_ONE;
      for (int i = 1; i < SAWD; i++) begin
        saw_q[i] <= saw_q[i-1];
      end
    end
  end

  // Stage 9: final multiply gives the Q30 magnitude of each lane.
  logic [61:0] mag_prod [2];
  logic [31:0] mag_q    [2];
  logic        neg_q    [2];

  for (genvar l = 0; l < 2; l++) begin : g_mag
    assign mag_prod[l] = 62'(poly_l[l][NPOLY].r) * 62'(poly_l[l][NPOLY].t);

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[l] <= mag_prod[l][61:30];
        neg_q[l] <= poly_l[l][NPOLY].neg;
      end
    end
  end

  // Stage 10: round to Q12, pick the non-tangent value, set up the divider.
  logic [32:0]        rnd [2];
  logic signed [19:0] q12 [2];
  logic               nz  [2];
  logic signed [19:0] alt;
  logic [43:0]        num;
  mwg_pkg::div_t      div_d;
  mwg_pkg::pass_t     pass_d;
  mwg_pkg::div_t      div_c  [NDIV+1];
  mwg_pkg::pass_t     pass_c [NDIV+1];

  for (genvar l = 0; l < 2; l++) begin : g_rnd
    assign rnd[l] = 33'(mag_q[l]) + 33'h2_0000;
    assign q12[l] = neg_q[l] ? -20'(rnd[l][32:18]) : 20'(rnd[l][32:18]);
    assign nz[l]  = (mag_q[l] != '0);
  end

  always_comb begin
    unique case (wave_type_q)
      mwg_pkg::WAVE_SINE:     alt = q12[0];
      mwg_pkg::WAVE_COSINE:   alt = q12[1];
      mwg_pkg::WAVE_SQUARE:   alt = (!neg_q[0] && nz[0]) ? mwg_pkg::VAL_ONE
                                                         : -mwg_pkg::VAL_ONE;
      mwg_pkg::WAVE_SAWTOOTH: alt = saw_q[SAWD-1];
      default:                alt = '0;
    endcase
  end

  assign num = {mag_q[0], 12'b0};

  always_comb begin
    div_d.rem   = num;
    div_d.den   = mag_q[1];
    div_d.quo   = '0;
    pass_d.alt  = alt;
    pass_d.tneg = (neg_q[0] && nz[0]) ^ (neg_q[1] && nz[1]);
    pass_d.zero = !nz[1];
    pass_d.spos = !neg_q[0] && nz[0];
    // A quotient of 2^20 or more saturates whatever its sign.
    pass_d.ovf  = (52'(num) >= {mag_q[1], 20'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_c[0]  <= div_d;
      pass_c[0] <= pass_d;
    end
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    mwg_div_cell #(
      .SHIFT (NDIV - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .div_i  (div_c[i]),
      .pass_i (pass_c[i]),
      .div_o  (div_c[i+1]),
      .pass_o (pass_c[i+1])
    );
  end

  // Final value: saturate the tangent quotient or take the other waveform.
  mwg_pkg::pass_t     pf;
  logic [19:0]        quo;
  logic signed [19:0] tan_v;
  logic signed [19:0] val_q;

  assign pf  = pass_c[NDIV];
  assign quo = div_c[NDIV].quo;

  always_comb begin
    if (pf.zero) begin
      tan_v = pf.spos ? mwg_pkg::VAL_MAX : mwg_pkg::VAL_MIN;
    end else if (pf.ovf) begin
      tan_v = pf.tneg ? mwg_pkg::VAL_MIN : mwg_pkg::VAL_MAX;
    end else if (pf.tneg) begin
      tan_v = (quo > 20'd524288) ? mwg_pkg::VAL_MIN : -$signed(quo);
    end else begin
      tan_v = (quo > 20'd524287) ? mwg_pkg::VAL_MAX : $signed(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= (wave_type_q == mwg_pkg::WAVE_TANGENT) ? tan_v : pf.alt;
    end
  end

  // Screen row with round-half-up and saturation; this is the output slot.
  logic signed [28:0] vprod;
  logic signed [31:0] tsum, rowf;
  logic signed [15:0] row_d, row_q;
  logic signed [19:0] out_val_q;

  assign vprod = val_q * $signed({1'b0, amp_q});
  assign tsum  = $signed({9'b0, mid_q, 12'b0}) - 32'(vprod) + 32'sd2048;
  assign rowf  = tsum >>> 12;

  always_comb begin
    if (rowf > 32'sd32767) begin
      row_d = 16'sh7FFF;
    end else if (rowf < -32'sd32768) begin
      row_d = -16'sh8000;
    end else begin
      row_d = rowf[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row_q     <= row_d;
      out_val_q <= val_q;
    end
  end

  assign m_axis_tvalid = vld_q[NSTAGE-1];
  assign m_axis_tdata  = {4'b0, row_q, out_val_q};

  // A held result must freeze the input side.
  `MWG_ASSERT_IMP(a_stall_blocks_input, vld_q[NSTAGE-1] && !m_axis_tready, !s_axis_tready)
  // An accepted transaction enters the first stage.
  `MWG_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0])
  // While stalled, no transaction is lost or created in the row.
  `MWG_ASSERT_NXT(a_stall_keeps_row, !en, $stable(vld_q))

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Waveform generator testbench
// Streams pixel columns and scroll times into the generator while checking
// every returned wave value and screen row against a bit-exact predictor.
// Register settings, stall patterns and back-pressure vary from test to test.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned PIPE_DRAIN   = 40;    // Cycles past the 32-stage pipeline.
  localparam int unsigned STALL_LIMIT  = 5000;  // Cycles with no transaction at all.
  localparam int unsigned LONG_HOLD    = 200;   // Receiver hold-off for the fill test.
  localparam int unsigned RANDOM_ITEMS = 290;   // Per idling phase, four phases.

  typedef struct packed {
    logic signed [19:0] wave_value;
    logic signed [15:0] screen_row;
  } plot_point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [11:0] cfg_data_i = '0;

  multi_waveform_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [2:0]  wave_sel  = 3'd0;
  logic [11:0] freq_q88  = 12'd768;
  logic [7:0]  amp_px    = 8'd100;
  logic [10:0] zero_row  = 11'd300;

  plot_point_t expected_points[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned points_checked = 0;
  int unsigned items_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // --------------------------------------------------------------------------
  // Predictor. The phase is (x*256 + t) * frequency * K / 2^56 turns; only
  // bits 40..55 of the 64-bit product matter, so unsigned wrap is harmless.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] turn_phase(logic [11:0] col, logic [23:0] tim);
    bit [63:0] scaled;
    bit [63:0] prod;
    scaled = ({52'd0, col} << 8) + {40'd0, tim};
    prod   = scaled * {52'd0, freq_q88} * 64'd1749927106;
    return {prod[55:40], 16'h0000};
  endfunction

  // Sine in Q30 from the quadrant and a degree-9 odd polynomial in the quarter.
  function automatic longint sine_q30(logic [31:0] ph);
    longint r;
    longint x2;
    longint acc;
    r = longint'(ph[29:0]);
    if (ph[30]) r = 64'sd1073741824 - r;
    x2  = (r * r) >>> 30;
    acc = 172273;
    acc = 5026995 - ((x2 * acc) >>> 30);
    acc = 85569306 - ((x2 * acc) >>> 30);
    acc = 693598670 - ((x2 * acc) >>> 30);
    acc = 1686629713 - ((x2 * acc) >>> 30);
    acc = (r * acc) >>> 30;
    return ph[31] ? -acc : acc;
  endfunction

  // Q30 to Q12 rounding to nearest, halves away from zero.
  function automatic longint round_q12(longint v);
    if (v >= 0) return (v + 131072) >>> 18;
    return -((-v + 131072) >>> 18);
  endfunction

  function automatic plot_point_t predict_point(logic [11:0] col, logic [23:0] tim);
    plot_point_t pt;
    logic [31:0] ph;
    logic [31:0] saw;
    longint      sn;
    longint      cs;
    longint      val;
    longint      row;
    ph  = turn_phase(col, tim);
    val = 0;
    case (wave_sel)
      mwg_pkg::WAVE_SINE:     val = round_q12(sine_q30(ph));
      mwg_pkg::WAVE_COSINE:   val = round_q12(sine_q30(ph + 32'h4000_0000));
      mwg_pkg::WAVE_TANGENT: begin
        sn = sine_q30(ph);
        cs = sine_q30(ph + 32'h4000_0000);
        if (cs == 0) val = (sn > 0) ? 524287 : -524288;
        else begin
          val = (sn * 4096) / cs;
          if (val > 524287) val = 524287;
          if (val < -524288) val = -524288;
        end
      end
      mwg_pkg::WAVE_SQUARE:   val = (sine_q30(ph) > 0) ? 4096 : -4096;
      mwg_pkg::WAVE_SAWTOOTH: begin
        saw = ph + 32'h8000_0000;
        val = longint'(saw >> 19) - 4096;
      end
      default:       val = 0;
    endcase
    // Arithmetic shift gives the floor division by 4096.
    row = (longint'(zero_row) * 4096 - val * longint'(amp_px) + 2048) >>> 12;
    if (row > 32767) row = 32767;
    if (row < -32768) row = -32768;
    pt.wave_value = val[19:0];
    pt.screen_row = row[15:0];
    return pt;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off whenever a test asks for it.
  // The hold is counted here so the sender keeps running meanwhile.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned holds_seen = 0;

  always @(posedge clk_i) begin
    if (holds_seen != hold_requests) begin
      holds_seen    <= hold_requests;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every output transaction is matched against the oldest expected point.
  always @(posedge clk_i) begin
    plot_point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result tdata=%h", m_axis_tdata);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (m_axis_tdata[19:0] !== want.wave_value ||
            m_axis_tdata[35:20] !== want.screen_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: wave_value exp %0d got %0d, screen_row exp %0d got %0d",
                     want.wave_value, $signed(m_axis_tdata[19:0]),
                     want.screen_row, $signed(m_axis_tdata[35:20]));
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction or write happens at all.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_points.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared driver tasks. All of them start and end right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic write_reg(mwg_pkg::cfg_reg_e idx, logic [11:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      mwg_pkg::REG_WAVE_TYPE: wave_sel = value[2:0];
      mwg_pkg::REG_FREQUENCY: freq_q88 = value;
      mwg_pkg::REG_AMPLITUDE: amp_px   = value[7:0];
      default:                zero_row = value[10:0];
    endcase
  endtask

  // Offers one column, with an optional random gap first, and records the
  // expected point once the transaction completes.
  task automatic send_item(logic [11:0] col, logic [23:0] tim);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'h0, tim, col};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_points.push_back(predict_point(col, tim));
    items_sent++;
  endtask

  // Stops offering and waits for the pipeline to empty out completely, so
  // that registers may be written afterwards.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    logic [11:0] col;
    logic [23:0] tim;
    repeat (count) begin
      col = 12'($urandom_range(4095));
      tim = 24'($urandom);
      // A slice of the items pins a field at its extremes.
      case ($urandom_range(9))
        0: col = 12'd0;
        1: col = 12'hFFF;
        2: tim = 24'd0;
        3: tim = 24'hFFFFFF;
        default: ;
      endcase
      send_item(col, tim);
    end
  endtask

  // Finds a scroll time that puts column 0 exactly on the given phase.
  function automatic logic [23:0] time_for_phase(logic [31:0] target);
    for (int unsigned t = 0; t < 24'hFFFFFF; t++)
      if (turn_phase(12'd0, t[23:0]) == target) return t[23:0];
    return 24'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes under the reset configuration, then every wave type,
  // including the undefined ones, at a handful of points.
  task automatic test_directed();
    send_item(12'd0, 24'd0);
    send_item(12'hFFF, 24'hFFFFFF);
    send_item(12'hFFF, 24'd0);
    send_item(12'd0, 24'hFFFFFF);
    send_item(12'h555, 24'hAAAAAA);
    drain_results();
    for (int w = 1; w < 8; w++) begin
      write_reg(mwg_pkg::REG_WAVE_TYPE, w[11:0]);
      send_item(12'd17, 24'h000080);
      send_item(12'hAAA, 24'h555555);
      drain_results();
    end
  endtask

  // Tangent exactly at zero cosine on both sides, and zero frequency.
  task automatic test_tangent_poles();
    write_reg(mwg_pkg::REG_WAVE_TYPE, 12'(mwg_pkg::WAVE_TANGENT));
    write_reg(mwg_pkg::REG_FREQUENCY, 12'd26);
    send_item(12'd0, time_for_phase(32'h4000_0000));
    send_item(12'd0, time_for_phase(32'hC000_0000));
    drain_results();
    write_reg(mwg_pkg::REG_FREQUENCY, 12'd0);
    send_item(12'd123, 24'h123456);
    drain_results();
    write_reg(mwg_pkg::REG_WAVE_TYPE, 12'(mwg_pkg::WAVE_SINE));
    send_item(12'hFFF, 24'hFFFFFF);
    drain_results();
  endtask

  // Random columns under one setting per idling phase, registers at their
  // extremes and beyond the documented ranges in turn.
  task automatic test_random_phases();
    int unsigned send_pct[4] = '{0, 56, 0, 18};
    int unsigned recv_pct[4] = '{0, 0, 56, 18};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mwg_pkg::REG_WAVE_TYPE, 12'($urandom_range(7)));
      case (ph)
        0: write_reg(mwg_pkg::REG_FREQUENCY, 12'd2560);
        1: write_reg(mwg_pkg::REG_FREQUENCY, 12'hFFF);
        2: write_reg(mwg_pkg::REG_FREQUENCY, 12'd26);
        default: write_reg(mwg_pkg::REG_FREQUENCY, 12'($urandom_range(4095)));
      endcase
      write_reg(mwg_pkg::REG_AMPLITUDE,
                (ph == 0) ? 12'd255 : (ph == 1) ? 12'd10 : 12'($urandom_range(255)));
      write_reg(mwg_pkg::REG_MID_Y,
                (ph == 0) ? 12'd2047 : (ph == 1) ? 12'd0 : 12'($urandom_range(2047)));
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      send_random(RANDOM_ITEMS);
      drain_results();
    end
    // Short bursts across all wave types with a random frequency.
    for (int w = 0; w < 8; w++) begin
      write_reg(mwg_pkg::REG_WAVE_TYPE, w[11:0]);
      write_reg(mwg_pkg::REG_FREQUENCY, 12'($urandom_range(4095)));
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      send_random(20);
      drain_results();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back
  // on the input; later the sender pauses until everything has come back.
  task automatic test_backpressure();
    write_reg(mwg_pkg::REG_WAVE_TYPE, 12'(mwg_pkg::WAVE_TANGENT));
    write_reg(mwg_pkg::REG_FREQUENCY, 12'd768);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_random(120);
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    recv_stall_pct = 56;
    send_random(60);
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tangent_poles();
    test_random_phases();
    test_backpressure();
    $display("Covered %0d input transactions and %0d checked results across all wave types,",
             items_sent, points_checked);
    $display("register extremes, random stalls and a full-pipeline hold-off.");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", mismatches,
               expected_points.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
